### rtl/ipt_pkg.sv
// Shared types and constants for the inverted page table with LRU replacement.
// No dependencies; used by every module of the block.
package ipt_pkg;

	localparam int PID_W   = 16;
	localparam int PAGE_W  = 20;
	localparam int OFF_W   = 16;
	localparam int FS_W    = 17;
	localparam int ADDR_W  = 22;
	localparam int FRAME_W = 6;
	localparam int STAMP_W = 64;

	localparam logic [FS_W-1:0] FS_RESET = FS_W'(4096);

	// One frame entry as held in the entry memory
	typedef struct packed {
		logic [PID_W-1:0]   pid;
		logic [PAGE_W-1:0]  page;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// Finished translation handed from the controller to the output stage
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [FRAME_W-1:0] frame;
		logic               hit;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WB,
		ST_DONE
	} state_t;

endpackage

### rtl/ipt_mem.sv
// Entry memory: one write port, one read port, registered read data.
// Depends on ipt_pkg for the entry type.
module ipt_mem #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  ipt_pkg::entry_t          wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output ipt_pkg::entry_t          rd_data
);
	import ipt_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/ipt_ctrl.sv
// Sequencer: clearing pass, entry scan for match and oldest stamp, write-back,
// and frame address multiply. Depends on ipt_pkg and ipt_mem.
module ipt_ctrl #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ipt_pkg::PID_W-1:0]  pid,
	input  logic [ipt_pkg::PAGE_W-1:0] page,
	input  logic [ipt_pkg::OFF_W-1:0]  offset,
	input  logic [ipt_pkg::FS_W-1:0]   fs,
	output logic                       res_valid,
	input  logic                       res_ready,
	output ipt_pkg::res_t              res
);
	import ipt_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int CNT_W  = IDX_W + 1;
	localparam int PROD_W = IDX_W + FS_W;
	localparam int SUM_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 1;

	state_t state_q, state_d;

	logic [CNT_W-1:0]   addr_q;
	logic               rvalid_s1;
	logic [IDX_W-1:0]   ridx_s1;
	logic               found_q;
	logic [IDX_W-1:0]   match_q;
	logic [IDX_W-1:0]   best_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [STAMP_W-1:0] count_q;
	logic [PID_W-1:0]   pid_q;
	logic [PAGE_W-1:0]  page_q;
	logic [OFF_W-1:0]   off_q;
	logic [IDX_W-1:0]   idx_q;
	logic               hit_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SUM_W-1:0]   sum;

	logic               rd_en;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;
	entry_t             rd_data;
	logic [IDX_W-1:0]   sel_idx;
	logic               scan_done;
	logic               clr_last;
	logic               accept;
	logic               rd_match;

	ipt_mem #(
		.DEPTH(TABLE_ENTRIES)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(addr_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	assign accept    = in_valid && in_ready;
	assign scan_done = (addr_q == CNT_W'(TABLE_ENTRIES)) && !rvalid_s1;
	assign clr_last  = (addr_q[IDX_W-1:0] == IDX_W'(TABLE_ENTRIES - 1));
	assign sel_idx   = found_q ? match_q : best_q;
	assign rd_match  = (rd_data.pid == pid_q) && (rd_data.page == page_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_SCAN;
			ST_SCAN:  if (scan_done) state_d = ST_WB;
			ST_WB:    state_d = ST_DONE;
			ST_DONE:  if (res_ready) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		rd_en     = (state_q == ST_SCAN) && (addr_q != CNT_W'(TABLE_ENTRIES));
		wr_en     = (state_q == ST_CLEAR) || (state_q == ST_WB);
		res_valid = (state_q == ST_DONE);
		if (state_q == ST_CLEAR) begin
			wr_addr = addr_q[IDX_W-1:0];
			wr_data = '0;
		end else begin
			wr_addr = sel_idx;
			// a hit rewrites the same pid and page, so both cases store the request
			wr_data = '{pid: pid_q, page: page_q, stamp: count_q + STAMP_W'(1)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			addr_q    <= '0;
			rvalid_s1 <= 1'b0;
			found_q   <= 1'b0;
			count_q   <= '0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= rd_en;
			if (state_q == ST_IDLE) begin
				addr_q <= '0;
			end else if ((state_q == ST_CLEAR) || rd_en) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			if (accept) begin
				found_q <= 1'b0;
			end else if (rvalid_s1 && rd_match) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_WB) begin
				count_q <= count_q + STAMP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= addr_q[IDX_W-1:0];
		if (accept) begin
			pid_q  <= pid;
			page_q <= page;
			off_q  <= offset;
		end
		if (rvalid_s1) begin
			// first match wins
			if (rd_match && !found_q) begin
				match_q <= ridx_s1;
			end
			// strict less keeps the lowest index on equal stamps
			if ((ridx_s1 == '0) || (rd_data.stamp < best_stamp_q)) begin
				best_q       <= ridx_s1;
				best_stamp_q <= rd_data.stamp;
			end
		end
		if (state_q == ST_WB) begin
			idx_q  <= sel_idx;
			hit_q  <= found_q;
			prod_q <= PROD_W'(sel_idx) * PROD_W'(fs);
		end
	end

	assign sum       = SUM_W'(prod_q) + SUM_W'(off_q);
	assign res.addr  = ADDR_W'(sum);
	assign res.frame = FRAME_W'(idx_q);
	assign res.hit   = hit_q;

endmodule

### rtl/inverted_page_table_lru.sv
// Inverted page table with LRU replacement. A request (pid, page, offset) is
// looked up against all TABLE_ENTRIES frame entries by scanning the entry
// memory through its single read port, one entry per cycle, while the first
// match and the oldest stamp are tracked. Requests are taken one at a
// time; the result waits in an output register so the next request can be
// taken meanwhile. After reset a clearing pass writes every entry to zero,
// during which no request is taken; frame_size writes are taken at any time
// but must only be issued while the block is idle.
module inverted_page_table_lru #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ipt_pkg::PID_W-1:0]    pid,
	input  logic [ipt_pkg::PAGE_W-1:0]   page,
	input  logic [ipt_pkg::OFF_W-1:0]    offset,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ipt_pkg::ADDR_W-1:0]   physical_address,
	output logic [ipt_pkg::FRAME_W-1:0]  frame,
	output logic                         hit,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ipt_pkg::FS_W-1:0]     frame_size
);
	import ipt_pkg::*;

	logic [FS_W-1:0] fs_q;
	logic            out_valid_q;
	logic            res_valid;
	logic            res_ready;
	res_t            res;
	res_t            res_q;

	ipt_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pid      (pid),
		.page     (page),
		.offset   (offset),
		.fs       (fs_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q        <= FS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				fs_q <= frame_size;
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign physical_address = res_q.addr;
	assign frame            = res_q.frame;
	assign hit              = res_q.hit;

endmodule

### rtl/ipt_checker.sv
// Port-level checks for inverted_page_table_lru, attached by bind.
// Depends on ipt_pkg for field widths.
module ipt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ipt_pkg::ADDR_W-1:0]  physical_address,
	input logic [ipt_pkg::FRAME_W-1:0] frame,
	input logic                        hit
);

	// a pending result is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(physical_address)
			&& $stable(frame) && $stable(hit))
		else $error("result dropped or changed while stalled");

	// the scan keeps the block busy after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("request taken during scan");

	// a fresh result only comes out of a request in progress
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

endmodule

bind inverted_page_table_lru ipt_checker u_ipt_checker (.*);
